// ===== hw/rtl/pgal_pkg.sv =====
// Shared types, constants and helpers of the colored page bitmap allocator.
`default_nettype none
package pgal_pkg;

  localparam int FRAME_W     = 40;
  localparam int SLOT_IN_W   = 3;
  localparam int GROUP_OUT_W = 4;

  localparam int DEF_CPU_SLOTS      = 8;
  localparam int DEF_GROUPS         = 16;
  localparam int DEF_PAGES_IN_GROUP = 64;
  localparam int DEF_WORD_BITS      = 64;

  localparam logic [FRAME_W-1:0] BASE_RESET = 40'd1053952;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef struct packed {
    logic                 opcode;
    logic [SLOT_IN_W-1:0] cpu_slot;
    logic [FRAME_W-1:0]   page_frame;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [FRAME_W-1:0]     alloc_frame;
    logic [GROUP_OUT_W-1:0] alloc_group;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_NGRD,
    S_SCAN,
    S_CLRBIT,
    S_MUL,
    S_ADD,
    S_DIV1,
    S_DIV2,
    S_DIV3,
    S_FRD,
    S_FWR
  } state_t;

  typedef enum logic [1:0] {
    DIV_GROUPS,
    DIV_PAGES,
    DIV_WORD
  } div_sel_t;

  typedef struct packed {
    logic run;
    logic done;
  } div_stat_t;

  function automatic int clog2_min1(input int v);
    return (v > 1) ? $clog2(v) : 1;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pgal_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
`default_nettype none
module pgal_ram #(
  parameter int DW    = 64,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/pgal_div.sv =====
// Constant-divisor divider by reciprocal multiplication on one shared multiplier.
`default_nettype none
module pgal_div import pgal_pkg::*; #(
  parameter int DW     = 13,
  parameter int VW     = 7,
  parameter int D_GRP  = DEF_GROUPS,
  parameter int D_PAGE = DEF_PAGES_IN_GROUP,
  parameter int D_WORD = DEF_WORD_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire div_sel_t      sel,
  input  wire logic [DW-1:0] dividend,
  output div_stat_t          stat,
  output logic      [DW-1:0] quo,
  output logic      [VW-1:0] rem
);

  localparam int SH_GRP  = DW + $clog2(D_GRP);
  localparam int SH_PAGE = DW + $clog2(D_PAGE);
  localparam int SH_WORD = DW + $clog2(D_WORD);
  localparam int MW0     = DW + 2;
  localparam int MW      = (MW0 > VW) ? MW0 : VW;
  localparam int PW      = DW + MW;
  localparam logic [MW-1:0] M_GRP  = MW'(((64'd1 << SH_GRP) + D_GRP - 1) / D_GRP);
  localparam logic [MW-1:0] M_PAGE = MW'(((64'd1 << SH_PAGE) + D_PAGE - 1) / D_PAGE);
  localparam logic [MW-1:0] M_WORD = MW'(((64'd1 << SH_WORD) + D_WORD - 1) / D_WORD);

  logic          run_r;
  logic          done_r;
  logic          ph_r;
  div_sel_t      sel_r;
  logic [DW-1:0] x_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;

  logic [MW-1:0] m_sel;
  logic [MW-1:0] d_sel;
  logic [DW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [DW-1:0] q_est;
  logic [DW-1:0] diff;

  always_comb begin
    case (sel_r)
      DIV_GROUPS: begin
        m_sel = M_GRP;
        d_sel = MW'(D_GRP);
      end
      DIV_PAGES: begin
        m_sel = M_PAGE;
        d_sel = MW'(D_PAGE);
      end
      DIV_WORD: begin
        m_sel = M_WORD;
        d_sel = MW'(D_WORD);
      end
      default: begin
        m_sel = M_GRP;
        d_sel = MW'(D_GRP);
      end
    endcase
  end

  assign mul_a = ph_r ? quo_r : x_r;
  assign mul_b = ph_r ? d_sel : m_sel;
  assign prod  = PW'(mul_a) * PW'(mul_b);
  assign diff  = x_r - prod[DW-1:0];

  always_comb begin
    case (sel_r)
      DIV_GROUPS: q_est = DW'(prod >> SH_GRP);
      DIV_PAGES:  q_est = DW'(prod >> SH_PAGE);
      DIV_WORD:   q_est = DW'(prod >> SH_WORD);
      default:    q_est = DW'(prod >> SH_GRP);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !run_r) begin
        run_r <= 1'b1;
        ph_r  <= 1'b0;
      end else if (run_r) begin
        ph_r <= !ph_r;
        if (ph_r) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !run_r) begin
      x_r   <= dividend;
      sel_r <= sel;
    end else if (run_r) begin
      if (!ph_r) begin
        quo_r <= q_est;
      end else begin
        rem_r <= VW'(diff);
      end
    end
  end

  assign stat.run  = run_r;
  assign stat.done = done_r;
  assign quo       = quo_r;
  assign rem       = rem_r;

endmodule
`default_nettype wire

// ===== hw/rtl/colored_page_bitmap_allocator.sv =====
// Top level of the colored page bitmap allocator: sequencer, bitmap memory and decode.
//
// A command is taken at a clock edge with start high and busy low. Opcode 0
// allocates a page for cpu_slot, opcode 1 returns page_frame to its pool.
// Every command gives exactly one result on out_item, shown for one cycle
// with out_valid high; the receiver cannot stall, so nothing is held back.
// The base frame is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// After reset the block marks every page free in the bitmap memory and zeroes
// the next-group table, one word per cycle, with busy high.
// An allocate reads one bitmap word per cycle from the slot's next group on;
// a hit clears its bit and forms the frame through S_CLRBIT, S_MUL and S_ADD,
// and a miss in every word of every group answers with ST_EMPTY. A command
// that fails at once answers in the next cycle.
// A free decodes the frame with three constant divisions on one shared
// multiplier, then reads and rewrites one word.
// Busy falls in the cycle the result is shown, so one command is processed
// at a time and the next one can be taken in that cycle.
`default_nettype none
module colored_page_bitmap_allocator import pgal_pkg::*; #(
  parameter int CPU_SLOTS      = DEF_CPU_SLOTS,
  parameter int GROUPS         = DEF_GROUPS,
  parameter int PAGES_IN_GROUP = DEF_PAGES_IN_GROUP,
  parameter int WORD_BITS      = DEF_WORD_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_item,
  output logic                    out_valid,
  output out_item_t               out_item,
  input  wire logic               cfg_we,
  input  wire logic [FRAME_W-1:0] cfg_wdata
);

  localparam int SW        = clog2_min1(CPU_SLOTS);
  localparam int GW        = clog2_min1(GROUPS);
  localparam int WPG       = (PAGES_IN_GROUP + WORD_BITS - 1) / WORD_BITS;
  localparam int KW        = clog2_min1(WPG);
  localparam int BW        = clog2_min1(WORD_BITS);
  localparam int GPW       = GROUPS * WPG;
  localparam int MAPW      = CPU_SLOTS * GPW;
  localparam int AW        = clog2_min1(MAPW);
  localparam int TOTAL     = CPU_SLOTS * GROUPS * PAGES_IN_GROUP;
  localparam int OW        = clog2_min1(TOTAL);
  localparam int NW        = clog2_min1(GPW + 1);
  localparam int DMAX0     = (GROUPS > PAGES_IN_GROUP) ? GROUPS : PAGES_IN_GROUP;
  localparam int DMAX      = (DMAX0 > WORD_BITS) ? DMAX0 : WORD_BITS;
  localparam int VW        = $clog2(DMAX + 1);
  localparam int LAST_BITS = PAGES_IN_GROUP - (WPG - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

  state_t             state_r, state_nxt;
  logic [FRAME_W-1:0] base_r, base_nxt;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic [AW-1:0]      slot_base_r, slot_base_nxt;
  logic [GW-1:0]      g_r, g_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic               chk_v_r, chk_v_nxt;
  logic               chk_last_r, chk_last_nxt;
  logic [GW-1:0]      chk_g_r, chk_g_nxt;
  logic [KW-1:0]      chk_k_r, chk_k_nxt;
  logic [AW-1:0]      chk_a_r, chk_a_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [GW-1:0]      fg_r, fg_nxt;
  logic [KW-1:0]      fk_r, fk_nxt;
  logic [AW-1:0]      fad_r, fad_nxt;
  logic [OW-1:0]      t_r, t_nxt;
  logic [OW-1:0]      q_r, q_nxt;
  logic [AW-1:0]      sg_r, sg_nxt;
  logic [BW-1:0]      bit_r, bit_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [KW-1:0]      clr_k_r, clr_k_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic                 map_we, map_re;
  logic [AW-1:0]        map_waddr, map_raddr;
  logic [WORD_BITS-1:0] map_wdata, map_rdata;
  logic                 ng_we, ng_re;
  logic [SW-1:0]        ng_waddr, ng_raddr;
  logic [GW-1:0]        ng_wdata, ng_rdata;

  logic          div_start;
  div_sel_t      div_sel;
  div_stat_t     div_stat;
  logic [OW-1:0] div_quo;
  logic [VW-1:0] div_rem;

  logic               accept;
  logic               slot_ok;
  logic [FRAME_W-1:0] off_full;
  logic               outside;
  logic               issue;
  logic [AW-1:0]      scan_addr;
  logic               hit;
  logic               miss_all;
  logic               clr_done;
  logic [WORD_BITS-1:0] lsb_onehot;
  logic [BW-1:0]      lsb_idx;

  pgal_ram #(
    .DW    (WORD_BITS),
    .DEPTH (MAPW),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  pgal_ram #(
    .DW    (GW),
    .DEPTH (CPU_SLOTS),
    .AW    (SW)
  ) u_next_group (
    .clk   (clk),
    .we    (ng_we),
    .waddr (ng_waddr),
    .wdata (ng_wdata),
    .re    (ng_re),
    .raddr (ng_raddr),
    .rdata (ng_rdata)
  );

  pgal_div #(
    .DW     (OW),
    .VW     (VW),
    .D_GRP  (GROUPS),
    .D_PAGE (PAGES_IN_GROUP),
    .D_WORD (WORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sel      (div_sel),
    .dividend (q_r),
    .stat     (div_stat),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign slot_ok   = (32'(in_item.cpu_slot) < CPU_SLOTS);
  assign off_full  = in_item.page_frame - base_r;
  assign outside   = (off_full >= FRAME_W'(TOTAL));
  assign issue     = (n_r != NW'(GPW));
  assign scan_addr = AW'(slot_base_r + g_r * WPG + k_r);
  assign hit       = chk_v_r && (map_rdata != '0);
  assign miss_all  = chk_v_r && chk_last_r && (map_rdata == '0);
  assign clr_done  = (clr_cnt_r == AW'(MAPW - 1));
  assign lsb_onehot = word_r & (~word_r + 1'b1);

  always_comb begin
    lsb_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lsb_onehot[i]) begin
        lsb_idx = lsb_idx | BW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_item.opcode == OP_ALLOC) begin
            state_nxt = slot_ok ? S_NGRD : S_IDLE;
          end else begin
            state_nxt = outside ? S_IDLE : S_DIV1;
          end
        end
      end
      S_NGRD:   state_nxt = S_SCAN;
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_CLRBIT;
        end else if (miss_all) begin
          state_nxt = S_IDLE;
        end
      end
      S_CLRBIT: state_nxt = S_MUL;
      S_MUL:    state_nxt = S_ADD;
      S_ADD:    state_nxt = S_IDLE;
      S_DIV1: begin
        if (div_stat.done) begin
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_stat.done) begin
          state_nxt = S_DIV3;
        end
      end
      S_DIV3: begin
        if (div_stat.done) begin
          state_nxt = S_FRD;
        end
      end
      S_FRD:    state_nxt = S_FWR;
      S_FWR:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    base_nxt      = cfg_we ? cfg_wdata : base_r;
    slot_nxt      = slot_r;
    slot_base_nxt = slot_base_r;
    g_nxt         = g_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    chk_v_nxt     = 1'b0;
    chk_last_nxt  = chk_last_r;
    chk_g_nxt     = chk_g_r;
    chk_k_nxt     = chk_k_r;
    chk_a_nxt     = chk_a_r;
    word_nxt      = word_r;
    fg_nxt        = fg_r;
    fk_nxt        = fk_r;
    fad_nxt       = fad_r;
    t_nxt         = t_r;
    q_nxt         = q_r;
    sg_nxt        = sg_r;
    bit_nxt       = bit_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_k_nxt     = clr_k_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    map_we      = 1'b0;
    map_waddr   = fad_r;
    map_wdata   = word_r & ~lsb_onehot;
    map_re      = 1'b0;
    map_raddr   = fad_r;
    ng_we       = 1'b0;
    ng_waddr    = slot_r;
    ng_wdata    = (fg_r == GW'(GROUPS - 1)) ? '0 : fg_r + 1'b1;
    ng_re       = 1'b0;
    ng_raddr    = SW'(in_item.cpu_slot);
    div_start   = 1'b0;
    div_sel     = DIV_GROUPS;

    case (state_r)
      S_CLEAR: begin
        map_we      = 1'b1;
        map_waddr   = clr_cnt_r;
        map_wdata   = (clr_k_r == KW'(WPG - 1)) ? LAST_MASK : '1;
        ng_we       = (32'(clr_cnt_r) < CPU_SLOTS);
        ng_waddr    = SW'(clr_cnt_r);
        ng_wdata    = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        clr_k_nxt   = (clr_k_r == KW'(WPG - 1)) ? '0 : clr_k_r + 1'b1;
      end
      S_IDLE: begin
        ng_re = 1'b1;
        if (accept) begin
          out_item_nxt.alloc_frame = '0;
          out_item_nxt.alloc_group = '0;
          if (in_item.opcode == OP_ALLOC) begin
            slot_nxt      = SW'(in_item.cpu_slot);
            slot_base_nxt = AW'(SW'(in_item.cpu_slot) * GPW);
            if (!slot_ok) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_EMPTY;
            end
          end else begin
            q_nxt = OW'(off_full);
            if (outside) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_OUTSIDE;
            end
          end
        end
      end
      S_NGRD: begin
        g_nxt = ng_rdata;
        k_nxt = '0;
        n_nxt = '0;
      end
      S_SCAN: begin
        map_re       = issue;
        map_raddr    = scan_addr;
        chk_v_nxt    = issue;
        chk_g_nxt    = g_r;
        chk_k_nxt    = k_r;
        chk_a_nxt    = scan_addr;
        chk_last_nxt = (n_r == NW'(GPW - 1));
        if (issue) begin
          n_nxt = n_r + 1'b1;
          if (k_r == KW'(WPG - 1)) begin
            k_nxt = '0;
            g_nxt = (g_r == GW'(GROUPS - 1)) ? '0 : g_r + 1'b1;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
        if (hit) begin
          word_nxt = map_rdata;
          fg_nxt   = chk_g_r;
          fk_nxt   = chk_k_r;
          fad_nxt  = chk_a_r;
        end else if (miss_all) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = ST_EMPTY;
          out_item_nxt.alloc_frame = '0;
          out_item_nxt.alloc_group = '0;
        end
      end
      S_CLRBIT: begin
        map_we = 1'b1;
        ng_we  = 1'b1;
        t_nxt  = OW'(slot_r * PAGES_IN_GROUP + fk_r * WORD_BITS + lsb_idx);
      end
      S_MUL: begin
        t_nxt = OW'(t_r * GROUPS + fg_r);
      end
      S_ADD: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.status      = ST_OK;
        out_item_nxt.alloc_frame = base_r + FRAME_W'(t_r);
        out_item_nxt.alloc_group = GROUP_OUT_W'(fg_r);
      end
      S_DIV1: begin
        div_start = !div_stat.run && !div_stat.done;
        div_sel   = DIV_GROUPS;
        if (div_stat.done) begin
          fg_nxt = GW'(div_rem);
          q_nxt  = div_quo;
        end
      end
      S_DIV2: begin
        div_start = !div_stat.run && !div_stat.done;
        div_sel   = DIV_PAGES;
        if (div_stat.done) begin
          sg_nxt = AW'(div_quo * GROUPS + fg_r);
          q_nxt  = OW'(div_rem);
        end
      end
      S_DIV3: begin
        div_start = !div_stat.run && !div_stat.done;
        div_sel   = DIV_WORD;
        if (div_stat.done) begin
          fad_nxt = AW'(sg_r * WPG + div_quo);
          bit_nxt = BW'(div_rem);
        end
      end
      S_FRD: begin
        map_re    = 1'b1;
        map_raddr = fad_r;
      end
      S_FWR: begin
        map_we                   = 1'b1;
        map_waddr                = fad_r;
        map_wdata                = map_rdata | (WORD_BITS'(1) << bit_r);
        out_valid_nxt            = 1'b1;
        out_item_nxt.status      = ST_OK;
        out_item_nxt.alloc_frame = '0;
        out_item_nxt.alloc_group = GROUP_OUT_W'(fg_r);
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      base_r      <= BASE_RESET;
      clr_cnt_r   <= '0;
      clr_k_r     <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_k_r     <= clr_k_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    slot_base_r <= slot_base_nxt;
    g_r         <= g_nxt;
    k_r         <= k_nxt;
    n_r         <= n_nxt;
    chk_last_r  <= chk_last_nxt;
    chk_g_r     <= chk_g_nxt;
    chk_k_r     <= chk_k_nxt;
    chk_a_r     <= chk_a_nxt;
    word_r      <= word_nxt;
    fg_r        <= fg_nxt;
    fk_r        <= fk_nxt;
    fad_r       <= fad_nxt;
    t_r         <= t_nxt;
    q_r         <= q_nxt;
    sg_r        <= sg_nxt;
    bit_r       <= bit_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("Result transfer during the memory clearing pass.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status != ST_OK)) |->
      ((out_item_r.alloc_frame == '0) && (out_item_r.alloc_group == '0)))
    else $error("Failed command returned a nonzero frame or group.");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid_r))
    else $error("Accepted command neither started nor answered.");

endmodule
`default_nettype wire

// ===== sim/tb_colored_page_bitmap_allocator.sv =====
// Self-checking testbench for the colored page bitmap allocator with a built-in pool predictor.
module tb_colored_page_bitmap_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import pgal_pkg::*;

  localparam int SLOTS      = DEF_CPU_SLOTS;
  localparam int NGRP       = DEF_GROUPS;
  localparam int PAGES      = DEF_PAGES_IN_GROUP;
  localparam int POOL_PAGES = NGRP * PAGES;
  localparam int TOTAL      = SLOTS * POOL_PAGES;
  localparam int SETTLE     = 64;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we;
  logic [FRAME_W-1:0] cfg_wdata;

  logic typed_ok;
  out_item_t typed_res;

  logic [PAGES-1:0] page_free [SLOTS][NGRP];
  logic [GROUP_OUT_W-1:0] next_grp [SLOTS];
  logic [FRAME_W-1:0] pool_base;
  logic [FRAME_W-1:0] taken_q[$];
  out_item_t pending_q[$];
  out_item_t predicted;
  out_item_t want;
  int errors = 0;
  int stall_cycles = 0;

  always #2 clk = ~clk;

  colored_page_bitmap_allocator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  task automatic flag_error(input string msg);
    if (errors < 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  function automatic void reset_pool();
    for (int s = 0; s < SLOTS; s++) begin
      for (int g = 0; g < NGRP; g++) begin
        page_free[s][g] = '1;
      end
      next_grp[s] = '0;
    end
    pool_base = BASE_RESET;
    taken_q.delete();
  endfunction

  function automatic out_item_t page_op(input in_item_t cmd);
    out_item_t r;
    logic [FRAME_W-1:0] off;
    int s, grp, idx, i;
    bit found;
    r.status = ST_OK;
    r.alloc_frame = '0;
    r.alloc_group = '0;
    found = 1'b0;
    if (cmd.opcode == OP_ALLOC) begin
      s = int'(cmd.cpu_slot);
      if (s < SLOTS) begin
        for (i = 0; i < NGRP && !found; i++) begin
          grp = (int'(next_grp[s]) + i) % NGRP;
          if (page_free[s][grp] != '0) begin
            idx = 0;
            while (!page_free[s][grp][idx]) idx++;
            page_free[s][grp][idx] = 1'b0;
            next_grp[s] = GROUP_OUT_W'((grp + 1) % NGRP);
            off = FRAME_W'(s * POOL_PAGES + idx * NGRP + grp);
            taken_q.push_back(off);
            r.alloc_frame = pool_base + off;
            r.alloc_group = GROUP_OUT_W'(grp);
            found = 1'b1;
          end
        end
      end
      if (!found) r.status = ST_EMPTY;
    end else begin
      off = cmd.page_frame - pool_base;
      if (off >= FRAME_W'(TOTAL)) begin
        r.status = ST_OUTSIDE;
      end else begin
        s = int'(off) / POOL_PAGES;
        grp = (int'(off) % POOL_PAGES) % NGRP;
        idx = (int'(off) % POOL_PAGES) / NGRP;
        page_free[s][grp][idx] = 1'b1;
        r.alloc_group = GROUP_OUT_W'(grp);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_pool();
      pending_q.delete();
    end else begin
      if (cfg_we) pool_base = cfg_wdata;
      if (start && !busy) begin
        predicted = page_op(in_item);
        pending_q.push_back(typed_ok ? typed_res : predicted);
      end
      if (out_valid) begin
        if (pending_q.size() == 0) begin
          flag_error($sformatf("unexpected result status %0d frame 0x%0h group %0d",
                               out_item.status, out_item.alloc_frame, out_item.alloc_group));
        end else begin
          want = pending_q.pop_front();
          if (out_item.status !== want.status || out_item.alloc_frame !== want.alloc_frame ||
              out_item.alloc_group !== want.alloc_group) begin
            flag_error($sformatf(
              "expected status %0d frame 0x%0h group %0d, got status %0d frame 0x%0h group %0d",
              want.status, want.alloc_frame, want.alloc_group,
              out_item.status, out_item.alloc_frame, out_item.alloc_group));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic dir_row_t row(input logic op, input int slot, input logic [FRAME_W-1:0] frame,
                                   input bit typed, input status_t st,
                                   input logic [FRAME_W-1:0] fr, input int grp);
    dir_row_t d;
    d.cmd.opcode = op;
    d.cmd.cpu_slot = SLOT_IN_W'(slot);
    d.cmd.page_frame = frame;
    d.typed = typed;
    d.res.status = st;
    d.res.alloc_frame = fr;
    d.res.alloc_group = GROUP_OUT_W'(grp);
    return d;
  endfunction

  task automatic send(input in_item_t cmd, input bit typed, input out_item_t res);
    while (busy) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_item = cmd;
    typed_ok = typed;
    typed_res = res;
    @(negedge clk);
  endtask

  task automatic idle(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_quiet();
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_base(input logic [FRAME_W-1:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_cmd(input bit drain, input int focus);
    in_item_t c;
    logic [63:0] w;
    logic [FRAME_W-1:0] off;
    int r, k;
    w = {$urandom(), $urandom()};
    c.opcode = OP_FREE;
    c.cpu_slot = SLOT_IN_W'($urandom());
    c.page_frame = w[FRAME_W-1:0];
    r = $urandom_range(0, 99);
    if (drain) begin
      if (r < 95) begin
        c.opcode = OP_ALLOC;
        c.cpu_slot = SLOT_IN_W'(focus);
      end
    end else if (r < 45) begin
      c.opcode = OP_ALLOC;
    end else if (r < 75 && taken_q.size() != 0) begin
      k = $urandom_range(0, taken_q.size() - 1);
      off = taken_q[k];
      taken_q.delete(k);
      c.page_frame = pool_base + off;
    end else if (r < 88) begin
      c.page_frame = pool_base + FRAME_W'($urandom_range(0, TOTAL - 1));
    end else if (r < 92) begin
      case ($urandom_range(0, 3))
        0: off = '0;
        1: off = FRAME_W'(TOTAL - 1);
        2: off = FRAME_W'(TOTAL);
        default: off = '1;
      endcase
      c.page_frame = pool_base + off;
    end
    return c;
  endfunction

  initial begin
    dir_row_t dir_rows[$];
    logic [FRAME_W-1:0] bases [5];
    int counts [5];
    logic [63:0] w;
    out_item_t none;
    bit burst;
    int focus;

    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    typed_ok = 1'b0;
    typed_res = '0;
    none = '0;
    burst = 1'b0;

    dir_rows.push_back(row(OP_ALLOC, 0, '0, 1, ST_OK, BASE_RESET, 0));
    dir_rows.push_back(row(OP_ALLOC, 0, '0, 1, ST_OK, BASE_RESET + 40'd1, 1));
    dir_rows.push_back(row(OP_ALLOC, 7, '0, 1, ST_OK, BASE_RESET + 40'd7168, 0));
    dir_rows.push_back(row(OP_FREE, 0, BASE_RESET - 40'd1, 1, ST_OUTSIDE, '0, 0));
    dir_rows.push_back(row(OP_FREE, 0, BASE_RESET + 40'd8192, 1, ST_OUTSIDE, '0, 0));
    dir_rows.push_back(row(OP_FREE, 0, '0, 1, ST_OUTSIDE, '0, 0));
    dir_rows.push_back(row(OP_FREE, 0, '1, 1, ST_OUTSIDE, '0, 0));
    dir_rows.push_back(row(OP_FREE, 0, BASE_RESET + 40'd8191, 1, ST_OK, '0, 15));
    dir_rows.push_back(row(OP_FREE, 0, BASE_RESET, 1, ST_OK, '0, 0));
    dir_rows.push_back(row(OP_FREE, 0, BASE_RESET, 1, ST_OK, '0, 0));
    dir_rows.push_back(row(OP_ALLOC, 0, '0, 1, ST_OK, BASE_RESET + 40'd2, 2));
    dir_rows.push_back(row(OP_ALLOC, 3, '0, 1, ST_OK, BASE_RESET + 40'd3072, 0));
    dir_rows.push_back(row(OP_FREE, 0, BASE_RESET + 40'd3072, 1, ST_OK, '0, 0));
    dir_rows.push_back(row(OP_ALLOC, 5, '1, 1, ST_OK, BASE_RESET + 40'd5120, 0));
    dir_rows.push_back(row(OP_FREE, 7, BASE_RESET + 40'd1, 1, ST_OK, '0, 1));
    repeat (4) dir_rows.push_back(row(OP_ALLOC, 0, '0, 0, ST_OK, '0, 0));
    dir_rows.push_back(row(OP_ALLOC, 1, '0, 0, ST_OK, '0, 0));
    dir_rows.push_back(row(OP_FREE, 0, BASE_RESET + 40'd3, 0, ST_OK, '0, 0));
    dir_rows.push_back(row(OP_FREE, 0, BASE_RESET + 40'd2047, 0, ST_OK, '0, 0));
    dir_rows.push_back(row(OP_FREE, 6, BASE_RESET + 40'd8176, 0, ST_OK, '0, 0));

    w = {$urandom(), $urandom()};
    bases[0] = '0;
    bases[1] = '1;
    bases[2] = w[FRAME_W-1:0];
    bases[3] = 40'hFF_FFFF_F800;
    bases[4] = BASE_RESET;
    counts[0] = 180;
    counts[1] = 180;
    counts[2] = 1120;
    counts[3] = 180;
    counts[4] = 140;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    while (busy) @(negedge clk);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
      idle(pick_gap(1'b0));
    end

    for (int ph = 0; ph < 5; ph++) begin
      wait_quiet();
      write_base(bases[ph]);
      focus = $urandom_range(0, SLOTS - 1);
      for (int n = 0; n < counts[ph]; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        send(make_cmd(ph == 2, focus), 1'b0, none);
        idle(pick_gap(burst));
      end
    end

    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (pending_q.size() != 0) flag_error("results still outstanding at end of run");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
